[src/assert_macros.svh]
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[src/lob_pkg.sv]
package lob_pkg;

  localparam int ORDER_SLOTS_DEF = 1024;
  localparam int LEVEL_SLOTS_DEF = 256;
  localparam int SUM_W = 42;
  localparam int CNT_W = 11;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_FILL   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN      = 3'd1,
    ST_ORDER_FULL   = 3'd2,
    ST_FILL_EXCEEDS = 3'd3,
    ST_LEVEL_FULL   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] order_ident;
    logic        buy_side;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [63:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             level_created;
    logic             level_removed;
    logic             order_removed;
    logic [SUM_W-1:0] level_total;
    logic [CNT_W-1:0] level_orders;
    logic [31:0]      best_bid_price;
    logic [31:0]      best_ask_price;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ident;
    logic        side;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [63:0] prio;
  } slot_t;

  typedef struct packed {
    logic             side;
    logic [31:0]      price;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } level_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_OSCAN, S_LINIT, S_LSCAN, S_PREP, S_DISP, S_UNLINK,
    S_RD1, S_WR1, S_RD2, S_WR2, S_APPEND, S_COMMIT, S_BINIT, S_BSCAN, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_INIT, OP_OSCAN, OP_LSCAN, OP_PREP, OP_UNLINK,
    OP_RD1, OP_WR1, OP_RD2, OP_WR2, OP_APPEND, OP_COMMIT, OP_BSCAN, OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic miss;
    logic err;
    logic need_unlink;
    logic need_append;
    logic pend1;
    logic pend2;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

[src/lob_ram.sv]
module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lob_ctrl.sv]
module lob_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lob_pkg::stat_t st,
  output lob_pkg::cmd_t  cmd
);
  import lob_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.op     = OP_NONE;
    cmd.accept = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        if (req_valid) state_next = S_OSCAN;
      end
      S_OSCAN: begin
        cmd.op = OP_OSCAN;
        if (st.hit) state_next = S_LINIT;
        else if (st.miss) state_next = S_BINIT;
      end
      S_LINIT: begin
        cmd.op = OP_INIT;
        state_next = S_LSCAN;
      end
      S_LSCAN: begin
        cmd.op = OP_LSCAN;
        if (st.hit) state_next = S_PREP;
        else if (st.miss) state_next = S_BINIT;
      end
      S_PREP: begin
        cmd.op = OP_PREP;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (st.err) state_next = S_BINIT;
        else if (st.need_unlink) state_next = S_UNLINK;
        else if (st.pend1) state_next = S_RD1;
        else if (st.pend2) state_next = S_RD2;
        else if (st.need_append) state_next = S_APPEND;
        else state_next = S_COMMIT;
      end
      S_UNLINK: begin
        cmd.op = OP_UNLINK;
        state_next = S_DISP;
      end
      S_RD1: begin
        cmd.op = OP_RD1;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.op = OP_WR1;
        state_next = S_DISP;
      end
      S_RD2: begin
        cmd.op = OP_RD2;
        state_next = S_WR2;
      end
      S_WR2: begin
        cmd.op = OP_WR2;
        state_next = S_DISP;
      end
      S_APPEND: begin
        cmd.op = OP_APPEND;
        state_next = S_DISP;
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
        state_next = S_BINIT;
      end
      S_BINIT: begin
        cmd.op = OP_INIT;
        state_next = S_BSCAN;
      end
      S_BSCAN: begin
        cmd.op = OP_BSCAN;
        if (st.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.op = OP_DONE;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[src/lob_dp.sv]
module lob_dp #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int LEVEL_SLOTS = lob_pkg::LEVEL_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lob_pkg::cmd_t  cmd,
  input  lob_pkg::req_t  req,
  output lob_pkg::stat_t st,
  output lob_pkg::rsp_t  rsp,
  output logic           rsp_valid,
  input  logic           rsp_ready
);
  import lob_pkg::*;

  localparam int OW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int LW = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
  localparam int SLOT_W = $bits(slot_t);
  localparam int LEVEL_W = $bits(level_t);

  // held request and working copies
  req_t             cur;
  logic [OW-1:0]    s_idx, s_next, s_prev;
  slot_t            srec;
  logic [LW-1:0]    lv;
  level_t           lrec;
  logic [OW-1:0]    l_head, l_tail;
  status_e          err_st;
  logic             created, lremoved, oremoved, empty_flag;
  logic             need_unlink, need_append, pend1, pend2;
  logic [OW-1:0]    p1_addr, p1_val, p2_addr, p2_val;
  // scan state
  logic [OW:0]      ocnt;
  logic [OW-1:0]    ochk;
  logic [LW:0]      lcnt;
  logic [LW-1:0]    lchk, free_lv;
  logic             chk_vld, free_found;
  logic [LEVEL_SLOTS-1:0] lvalid;
  logic [31:0]      top_bid, top_ask;
  logic             any_bid, any_ask;
  logic [OW-1:0]    clr_cnt;

  // memory ports
  logic             sm_we, sl_we, lm_we, ll_we;
  logic [OW-1:0]    sm_waddr, sl_waddr, s_raddr, ll_wdata_h;
  logic [LW-1:0]    l_waddr, l_raddr;
  slot_t            sm_wdata, sm_rdata;
  logic [2*OW-1:0]  sl_wdata, sl_rdata, ll_wdata, ll_rdata;
  level_t           lm_wdata, lm_rdata;

  lob_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_slot_main (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(s_raddr), .rdata(sm_rdata));
  lob_ram #(.WIDTH(2*OW), .DEPTH(ORDER_SLOTS)) u_slot_link (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(s_raddr), .rdata(sl_rdata));
  lob_ram #(.WIDTH(LEVEL_W), .DEPTH(LEVEL_SLOTS)) u_level_main (
    .clk(clk), .we(lm_we), .waddr(l_waddr), .wdata(lm_wdata),
    .raddr(l_raddr), .rdata(lm_rdata));
  lob_ram #(.WIDTH(2*OW), .DEPTH(LEVEL_SLOTS)) u_level_link (
    .clk(clk), .we(ll_we), .waddr(l_waddr), .wdata(ll_wdata),
    .raddr(l_raddr), .rdata(ll_rdata));

  logic          is_ins, o_match, o_end, l_match, l_end, free_now, lv_ok;
  logic [LW-1:0] free_idx;
  logic          key_side;
  logic [31:0]   key_price, rem, qty;
  logic          is_head, is_tail, chk_lvalid;

  always_comb begin
    is_ins     = (cur.action == ACT_INSERT);
    key_side   = is_ins ? cur.buy_side : srec.side;
    key_price  = is_ins ? cur.limit_price : srec.price;
    o_match    = chk_vld && (is_ins ? !sm_rdata.valid
                 : (sm_rdata.valid && (sm_rdata.ident == cur.order_ident)));
    o_end      = (ocnt == (OW+1)'(ORDER_SLOTS));
    chk_lvalid = lvalid[lchk];
    l_match    = chk_vld && chk_lvalid && (lm_rdata.side == key_side)
                 && (lm_rdata.price == key_price);
    l_end      = (lcnt == (LW+1)'(LEVEL_SLOTS));
    free_now   = free_found || (chk_vld && !chk_lvalid);
    free_idx   = free_found ? free_lv : lchk;
    lv_ok      = l_match || (l_end && is_ins && free_now);
    rem        = srec.remaining;
    qty        = cur.quantity;
    is_head    = (l_head == s_idx);
    is_tail    = (l_tail == s_idx);
    ll_wdata_h = l_head;
  end

  // memory port selection
  always_comb begin
    sm_we    = 1'b0;
    sl_we    = 1'b0;
    lm_we    = 1'b0;
    ll_we    = 1'b0;
    sm_waddr = s_idx;
    sl_waddr = s_idx;
    sm_wdata = srec;
    sl_wdata = {s_next, s_prev};
    s_raddr  = ocnt[OW-1:0];
    l_raddr  = lcnt[LW-1:0];
    l_waddr  = lv;
    lm_wdata = lrec;
    ll_wdata = {ll_wdata_h, l_tail};
    case (cmd.op)
      OP_CLEAR: begin
        sm_we    = 1'b1;
        sm_waddr = clr_cnt;
        sm_wdata = '0;
      end
      OP_RD1: s_raddr = p1_addr;
      OP_WR1: begin
        sl_we    = 1'b1;
        sl_waddr = p1_addr;
        sl_wdata = {p1_val, sl_rdata[OW-1:0]};
      end
      OP_RD2: s_raddr = p2_addr;
      OP_WR2: begin
        sl_we    = 1'b1;
        sl_waddr = p2_addr;
        sl_wdata = {sl_rdata[2*OW-1:OW], p2_val};
      end
      OP_COMMIT: begin
        sm_we = 1'b1;
        sl_we = 1'b1;
        lm_we = 1'b1;
        ll_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.clr_done    = (cmd.op == OP_CLEAR) && (clr_cnt == OW'(ORDER_SLOTS - 1));
    st.hit         = ((cmd.op == OP_OSCAN) && o_match) || ((cmd.op == OP_LSCAN) && lv_ok);
    st.miss        = ((cmd.op == OP_OSCAN) && !o_match && o_end)
                     || ((cmd.op == OP_LSCAN) && !lv_ok && l_end);
    st.err         = (err_st != ST_OK);
    st.need_unlink = need_unlink;
    st.need_append = need_append;
    st.pend1       = pend1;
    st.pend2       = pend2;
    st.scan_done   = (cmd.op == OP_BSCAN) && l_end && !chk_vld;
    st.out_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid    <= '0;
      rsp_valid <= 1'b0;
      clr_cnt   <= '0;
      chk_vld   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (cmd.op != OP_DONE)) rsp_valid <= 1'b0;
      if (cmd.accept) begin
        cur         <= req;
        ocnt        <= '0;
        chk_vld     <= 1'b0;
        err_st      <= ST_OK;
        created     <= 1'b0;
        lremoved    <= 1'b0;
        oremoved    <= 1'b0;
        need_unlink <= 1'b0;
        need_append <= 1'b0;
        pend1       <= 1'b0;
        pend2       <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        OP_INIT: begin
          lcnt       <= '0;
          chk_vld    <= 1'b0;
          free_found <= 1'b0;
          any_bid    <= 1'b0;
          any_ask    <= 1'b0;
          top_bid    <= '0;
          top_ask    <= '0;
        end
        OP_OSCAN: begin
          if (o_match) begin
            s_idx  <= ochk;
            srec   <= sm_rdata;
            s_next <= sl_rdata[2*OW-1:OW];
            s_prev <= sl_rdata[OW-1:0];
          end else if (!o_end) begin
            ocnt    <= ocnt + 1'b1;
            ochk    <= ocnt[OW-1:0];
            chk_vld <= 1'b1;
          end else begin
            err_st <= is_ins ? ST_ORDER_FULL : ST_UNKNOWN;
          end
        end
        OP_LSCAN: begin
          if (chk_vld && !chk_lvalid && !free_found) begin
            free_found <= 1'b1;
            free_lv    <= lchk;
          end
          if (l_match) begin
            lv     <= lchk;
            lrec   <= lm_rdata;
            l_head <= ll_rdata[2*OW-1:OW];
            l_tail <= ll_rdata[OW-1:0];
          end else if (!l_end) begin
            lcnt    <= lcnt + 1'b1;
            lchk    <= lcnt[LW-1:0];
            chk_vld <= 1'b1;
          end else if (is_ins && free_now) begin
            lv         <= free_idx;
            lrec.side  <= cur.buy_side;
            lrec.price <= cur.limit_price;
            lrec.sum   <= '0;
            lrec.count <= '0;
            created    <= 1'b1;
          end else begin
            err_st <= is_ins ? ST_LEVEL_FULL : ST_UNKNOWN;
          end
        end
        OP_PREP: begin
          case (action_e'(cur.action))
            ACT_INSERT: begin
              srec.valid     <= 1'b1;
              srec.ident     <= cur.order_ident;
              srec.side      <= cur.buy_side;
              srec.price     <= cur.limit_price;
              srec.remaining <= qty;
              srec.prio      <= cur.priority_req;
              need_append    <= 1'b1;
              empty_flag     <= created;
              lrec.sum       <= lrec.sum + SUM_W'(qty);
              lrec.count     <= lrec.count + 1'b1;
            end
            ACT_CANCEL: begin
              need_unlink <= 1'b1;
              lrec.sum    <= lrec.sum - SUM_W'(rem);
              lrec.count  <= lrec.count - 1'b1;
              srec.valid  <= 1'b0;
              oremoved    <= 1'b1;
            end
            ACT_MODIFY: begin
              // decrease keeps place; increase requeues at the tail
              lrec.sum       <= lrec.sum - SUM_W'(rem) + SUM_W'(qty);
              srec.remaining <= qty;
              if (qty > rem) begin
                srec.prio   <= cur.priority_req;
                need_unlink <= 1'b1;
                need_append <= 1'b1;
              end
            end
            ACT_FILL: begin
              if (qty > rem) begin
                err_st <= ST_FILL_EXCEEDS;
              end else begin
                lrec.sum       <= lrec.sum - SUM_W'(qty);
                srec.remaining <= rem - qty;
                if (qty == rem) begin
                  need_unlink <= 1'b1;
                  lrec.count  <= lrec.count - 1'b1;
                  srec.valid  <= 1'b0;
                  oremoved    <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        OP_UNLINK: begin
          need_unlink <= 1'b0;
          if (is_head && is_tail) begin
            empty_flag <= 1'b1;
            lremoved   <= (cur.action != ACT_MODIFY);
          end else begin
            empty_flag <= 1'b0;
            if (is_head) begin
              l_head <= s_next;
            end else begin
              pend1   <= 1'b1;
              p1_addr <= s_prev;
              p1_val  <= s_next;
            end
            if (is_tail) begin
              l_tail <= s_prev;
            end else begin
              pend2   <= 1'b1;
              p2_addr <= s_next;
              p2_val  <= s_prev;
            end
          end
        end
        OP_WR1: pend1 <= 1'b0;
        OP_WR2: pend2 <= 1'b0;
        OP_APPEND: begin
          need_append <= 1'b0;
          if (empty_flag) begin
            l_head <= s_idx;
            s_prev <= s_idx;
          end else begin
            pend1   <= 1'b1;
            p1_addr <= l_tail;
            p1_val  <= s_idx;
            s_prev  <= l_tail;
          end
          s_next <= s_idx;
          l_tail <= s_idx;
        end
        OP_COMMIT: lvalid[lv] <= !lremoved;
        OP_BSCAN: begin
          if (chk_vld && chk_lvalid) begin
            if (lm_rdata.side) begin
              if (!any_bid || (lm_rdata.price > top_bid)) begin
                top_bid <= lm_rdata.price;
                any_bid <= 1'b1;
              end
            end else if (!any_ask || (lm_rdata.price < top_ask)) begin
              top_ask <= lm_rdata.price;
              any_ask <= 1'b1;
            end
          end
          if (!l_end) begin
            lcnt    <= lcnt + 1'b1;
            lchk    <= lcnt[LW-1:0];
            chk_vld <= 1'b1;
          end else begin
            chk_vld <= 1'b0;
          end
        end
        OP_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp.status         <= err_st;
            rsp.level_created  <= created;
            rsp.level_removed  <= lremoved;
            rsp.order_removed  <= oremoved;
            rsp.level_total    <= ((err_st == ST_OK) && !lremoved) ? lrec.sum : '0;
            rsp.level_orders   <= ((err_st == ST_OK) && !lremoved) ? lrec.count : '0;
            rsp.best_bid_price <= top_bid;
            rsp.best_ask_price <= top_ask;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[src/limit_order_book_engine_core.sv]
// The order table scan (one entry per cycle) and up to two level table scans
// dominate the time taken per request.
// One request at a time; the next is taken the cycle after the result is registered.
// Reset (rst, synchronous): a clearing pass over every order slot empties the order
// table; req_ready stays low until it ends. Level valid bits clear at once.
`include "assert_macros.svh"

module limit_order_book_engine_core #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int LEVEL_SLOTS = lob_pkg::LEVEL_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lob_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lob_pkg::rsp_t rsp
);
  import lob_pkg::*;

  // Command and status between the sequencer and the table datapath.
  cmd_t  cmd;
  stat_t st;

  // Sequencer: scan orders, scan levels, prepare totals, walk the link
  // updates one read-modify-write at a time, commit, then rescan best prices.
  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: order and level tables in RAM, level valid bits in flops,
  // and the registered result that decouples the response side.
  lob_dp #(
    .ORDER_SLOTS (ORDER_SLOTS),
    .LEVEL_SLOTS (LEVEL_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .st        (st),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  // One request in flight: after an accept the block stops taking requests.
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "second request taken while busy")
  // A scan resolves one way only.
  `ASSERT_IMPLY(a_scan_exclusive, clk, rst, st.hit, !st.miss, "scan reported both hit and miss")
  // A new result appears only out of the result step.
  `ASSERT_IMPLY(a_rsp_source, clk, rst, $rose(rsp_valid), $past(cmd.op == OP_DONE), "result without result step")

endmodule
